/* src/trd_pkg.sv */
package trd_pkg;

    // Field widths of one transaction.
    localparam int COORD_W  = 16;
    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 24;
    localparam int COUNT_W  = 17;
    localparam int FRAME_W  = 9;
    localparam int INDEX_W  = 16;

    // Internal arithmetic widths.
    localparam int LIM_W    = 13;  // box bounds, up to 2048
    localparam int OPND_W   = 18;  // multiplier operands
    localparam int PROD_W   = 36;  // multiplier product
    localparam int AREA_W   = 37;  // edge function and triangle area
    localparam int WEIGHT_W = 34;  // a non-negative weight never exceeds the area
    localparam int CHUNK_W  = 17;  // half of a weight
    localparam int ACC_W    = 51;  // depth-weighted sum
    localparam int NUM_W    = 51;  // offset dividend
    localparam int DEN_W    = 35;  // twice the area
    localparam int QUOT_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic signed [DEPTH_W-1:0] FAR_DEPTH      = 16'sh7FFF;
    localparam logic signed [AREA_W-1:0]  MIN_TWICE_AREA = 37'sd512;

    typedef enum logic [0:0] {
        KIND_DRAW = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind                      kind;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [DEPTH_W-1:0]  az;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by_coord;
        logic signed [DEPTH_W-1:0]  bz;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [DEPTH_W-1:0]  cz;
        logic [COLOR_W-1:0]         fill_color;
        logic [INDEX_W-1:0]         pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0]         pixels_written;
        logic                       culled;
        logic signed [DEPTH_W-1:0]  read_depth;
        logic [COLOR_W-1:0]         read_color;
    } t_out_item;

    function automatic logic signed [COORD_W-1:0] min3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [COORD_W-1:0] max3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Q12.4 to whole pixels, nearest with ties away from zero, clamped to [0, lim].
    // Any negative coordinate rounds to zero or below, so it clamps to zero.
    function automatic logic [LIM_W-1:0] round_clamp(
        input logic signed [COORD_W-1:0] v,
        input logic [LIM_W-1:0]          lim
    );
        logic [COORD_W:0] sum;
        logic [LIM_W-1:0] r;
        sum = {2'b00, v[COORD_W-2:0]} + 17'd8;
        r   = sum[COORD_W:4];
        if (v[COORD_W-1]) begin
            return '0;
        end
        return (r > lim) ? lim : r;
    endfunction

endpackage

/* src/trd_if.sv */
// Draw or read request channel.
interface trd_in_if;
    logic              valid;
    logic              ready;
    trd_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface trd_out_if;
    logic               valid;
    logic               ready;
    trd_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Register write channel.
interface trd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [trd_pkg::CFG_IDX_W-1:0]   index;
    logic [trd_pkg::FRAME_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/trd_ram.sv */
module trd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* src/trd_div.sv */
module trd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [trd_pkg::NUM_W-1:0]     i_num,
    input  logic [trd_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [trd_pkg::QUOT_W-1:0]    o_quot
);
    import trd_pkg::*;

    localparam int SH_W  = DEN_W + QUOT_W - 1;
    localparam int CNT_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  r_rem;
    logic [SH_W-1:0]   r_dsh;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign ge = (r_rem >= NUM_W'(r_dsh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, {(QUOT_W-1){1'b0}}};
            r_cnt <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - NUM_W'(r_dsh);
            end
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* src/triangle_raster_depth_test_unit.sv */
// Channel   Dir  Payload                                   Transaction
// i_in      in   kind, vertices, fill_color, pixel_index   valid & ready
// o_out     out  pixels_written, culled, read_depth/color  valid & ready
// i_cfg     in   index, data (frame_width, frame_height)   valid & ready (ready always high)
//
// After reset a clearing pass writes every store entry, with i_in.ready low. A draw runs
// setup (twice the area and the cull test; a culled draw ends there), then visits each
// pixel of the clamped box: a pixel off the frame is skipped, one outside the triangle
// ends after its weights, and a covered one uses the shared multiplier (6 weight and 6 depth
// products), the 16-step divider and the read-compare-write of the store; S_FINISH ends it.
// One item is in work at a time; a finished result waits in the output register and
// the block stalls only when the next result is ready before that one is taken.
module triangle_raster_depth_test_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trd_in_if.sink      i_in,
    trd_out_if.source   o_out,
    trd_cfg_if.sink     i_cfg
);
    import trd_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int YW     = $clog2(MAX_HEIGHT + 1);
    localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(STORE);
    localparam int WORD_W = DEPTH_W + COLOR_W;
    localparam int CW     = (XW > FRAME_W) ? XW : FRAME_W;
    localparam int CH     = (YW > FRAME_W) ? YW : FRAME_W;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_SETUP  = 11'b00000000100,
        S_PIXEL  = 11'b00000001000,
        S_WGT    = 11'b00000010000,
        S_NUM    = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_RD     = 11'b00010000000,
        S_CMP    = 11'b00100000000,
        S_READ   = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [FRAME_W-1:0]       r_fw, r_fh;
    t_in_item                 r_item;
    logic [2:0]               r_step;
    logic [XW-1:0]            r_x, r_x0, r_x1;
    logic [YW-1:0]            r_y, r_y0, r_y1;
    logic signed [AREA_W-1:0] r_d, r_wa, r_wb, r_wc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DEPTH_W-1:0]       r_z;
    logic [COUNT_W-1:0]       r_count;
    logic                     r_culled;
    logic [AW-1:0]            r_clr;
    logic                     r_ov;
    t_out_item                r_out;

    logic [XW-1:0]            w_eff;
    logic [YW-1:0]            h_eff;
    logic                     in_acc, can_finish, last_pix, oob, covered, cull, adv;
    logic [2:0]               prev;
    logic signed [AREA_W-1:0] prod_e, wc_fin, d_fin;
    logic signed [ACC_W-1:0]  term, acc_next;
    logic signed [OPND_W-1:0] m_a, m_b;
    logic signed [OPND_W-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e, px_e, py_e;
    logic signed [AREA_W-1:0] w_sel;
    logic signed [DEPTH_W-1:0] z_sel;
    logic [CHUNK_W-1:0]       chunk;
    logic [WEIGHT_W-1:0]      d_u;
    logic [NUM_W-1:0]         div_num;
    logic                     div_start, div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic [AW-1:0]            pix_idx;
    logic                     ram_we, ram_re, pass, rd_in_range;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [WORD_W-1:0]        ram_wdata, ram_rdata;

    // Frame sizes saturated to the store.
    assign w_eff = (CW'(r_fw) > CW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : XW'(r_fw);
    assign h_eff = (CH'(r_fh) > CH'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(r_fh);

    assign in_acc     = i_in.valid && i_in.ready;
    assign can_finish = !r_ov || o_out.ready;
    assign last_pix   = (r_x == r_x1) && (r_y == r_y1);
    assign oob        = (r_x >= w_eff) || (r_y >= h_eff);
    assign prev       = r_step - 3'd1;

    // Operands, vertices sign-extended and the pixel centre at (16x, 16y).
    assign ax_e = OPND_W'(r_item.ax);
    assign ay_e = OPND_W'(r_item.ay);
    assign bx_e = OPND_W'(r_item.bx);
    assign by_e = OPND_W'(r_item.by_coord);
    assign cx_e = OPND_W'(r_item.cx);
    assign cy_e = OPND_W'(r_item.cy);
    assign px_e = $signed(OPND_W'({r_x, 4'b0000}));
    assign py_e = $signed(OPND_W'({r_y, 4'b0000}));

    // Depth term and weight half for the depth-weighted sum.
    always_comb begin
        case (r_step[2:1])
            2'd0:    begin z_sel = r_item.az; w_sel = r_wa; end
            2'd1:    begin z_sel = r_item.bz; w_sel = r_wb; end
            default: begin z_sel = r_item.cz; w_sel = r_wc; end
        endcase
        chunk = r_step[0] ? w_sel[WEIGHT_W-1:CHUNK_W] : w_sel[CHUNK_W-1:0];
    end

    // Shared multiplier operand selection.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_SETUP: begin
                if (r_step == 3'd0) begin
                    m_a = bx_e - ax_e; m_b = cy_e - ay_e;
                end else begin
                    m_a = cx_e - ax_e; m_b = by_e - ay_e;
                end
            end
            S_WGT: begin
                case (r_step)
                    3'd0:    begin m_a = bx_e - px_e; m_b = cy_e - py_e; end
                    3'd1:    begin m_a = cx_e - px_e; m_b = by_e - py_e; end
                    3'd2:    begin m_a = px_e - ax_e; m_b = cy_e - ay_e; end
                    3'd3:    begin m_a = cx_e - ax_e; m_b = py_e - ay_e; end
                    3'd4:    begin m_a = bx_e - ax_e; m_b = py_e - ay_e; end
                    3'd5:    begin m_a = px_e - ax_e; m_b = by_e - ay_e; end
                    default: begin m_a = '0; m_b = '0; end
                endcase
            end
            S_NUM: begin
                m_a = OPND_W'(z_sel);
                m_b = $signed({1'b0, chunk});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Accumulation of the product registered in the previous cycle.
    assign prod_e   = AREA_W'(r_prod);
    assign wc_fin   = r_wc - prod_e;
    assign d_fin    = r_d - prod_e;
    assign covered  = !r_wa[AREA_W-1] && !r_wb[AREA_W-1] && !wc_fin[AREA_W-1];
    assign cull     = (d_fin < MIN_TWICE_AREA);
    assign term     = prev[0] ? (ACC_W'(r_prod) <<< CHUNK_W) : ACC_W'(r_prod);
    assign acc_next = (prev == 3'd0) ? term : (r_acc + term);

    // Dividend offset so that the quotient is floor(num / den) + 32768.
    assign d_u       = r_d[WEIGHT_W-1:0];
    assign div_num   = NUM_W'(unsigned'(acc_next <<< 1)) + {17'b0, d_u} + {1'b0, d_u, 16'b0};
    assign div_start = (r_state == S_NUM) && (r_step == 3'd6);

    trd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({d_u, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Store access: clearing pass, pixel read-modify-write and read items.
    assign pix_idx     = AW'(int'(r_y) * MAX_WIDTH + int'(r_x));
    assign pass        = $signed(r_z) <= $signed(ram_rdata[WORD_W-1:COLOR_W]);
    assign rd_in_range = int'(r_item.pixel_index) < STORE;
    assign ram_we      = (r_state == S_CLEAR) || ((r_state == S_CMP) && pass);
    assign ram_waddr   = (r_state == S_CLEAR) ? r_clr : pix_idx;
    assign ram_wdata   = (r_state == S_CLEAR) ? {FAR_DEPTH, {COLOR_W{1'b0}}}
                                              : {r_z, r_item.fill_color};
    assign ram_re      = (r_state == S_RD) || (r_state == S_READ);
    assign ram_raddr   = (r_state == S_READ) ? AW'(r_item.pixel_index) : pix_idx;

    trd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Move to the next pixel of the box.
    assign adv = ((r_state == S_PIXEL) && oob)
              || ((r_state == S_WGT) && (r_step == 3'd6) && !covered)
              || (r_state == S_CMP);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(STORE - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = (i_in.data.kind == KIND_READ) ? S_READ : S_SETUP;
            end
            S_SETUP: begin
                if (r_step == 3'd2) n_state = cull ? S_FINISH : S_PIXEL;
            end
            S_PIXEL: begin
                if (oob) n_state = last_pix ? S_FINISH : S_PIXEL;
                else     n_state = S_WGT;
            end
            S_WGT: begin
                if (r_step == 3'd6) begin
                    if (covered) n_state = S_NUM;
                    else         n_state = last_pix ? S_FINISH : S_PIXEL;
                end
            end
            S_NUM: begin
                if (r_step == 3'd6) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_RD;
            end
            S_RD:     n_state = S_CMP;
            S_CMP:    n_state = last_pix ? S_FINISH : S_PIXEL;
            S_READ:   n_state = S_FINISH;
            S_FINISH: begin
                if (can_finish) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_step  <= '0;
            r_ov    <= 1'b0;
            r_fw    <= 9'd256;
            r_fh    <= 9'd256;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (((r_state == S_SETUP) || (r_state == S_WGT) || (r_state == S_NUM))
                && (n_state == r_state)) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if ((r_state == S_FINISH) && can_finish) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FRAME_WIDTH:  r_fw <= i_cfg.data;
                    CFG_FRAME_HEIGHT: r_fh <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (in_acc) begin
            r_item <= i_in.data;
        end
        case (r_state)
            S_SETUP: begin
                if (r_step == 3'd0) begin
                    r_x0 <= XW'(round_clamp(min3(r_item.ax, r_item.bx, r_item.cx),
                                            LIM_W'(w_eff)));
                    r_x1 <= XW'(round_clamp(max3(r_item.ax, r_item.bx, r_item.cx),
                                            LIM_W'(w_eff)));
                    r_y0 <= YW'(round_clamp(min3(r_item.ay, r_item.by_coord, r_item.cy),
                                            LIM_W'(h_eff)));
                    r_y1 <= YW'(round_clamp(max3(r_item.ay, r_item.by_coord, r_item.cy),
                                            LIM_W'(h_eff)));
                end else if (r_step == 3'd1) begin
                    r_d <= prod_e;
                end else begin
                    r_d      <= d_fin;
                    r_culled <= cull;
                    r_count  <= '0;
                    r_x      <= r_x0;
                    r_y      <= r_y0;
                end
            end
            S_WGT: begin
                case (prev)
                    3'd0:    r_wa <= prod_e;
                    3'd1:    r_wa <= r_wa - prod_e;
                    3'd2:    r_wb <= prod_e;
                    3'd3:    r_wb <= r_wb - prod_e;
                    3'd4:    r_wc <= prod_e;
                    3'd5:    r_wc <= wc_fin;
                    default: ;
                endcase
            end
            S_NUM: begin
                if (r_step != 3'd0) begin
                    r_acc <= acc_next;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_z <= {~div_quot[QUOT_W-1], div_quot[QUOT_W-2:0]};
                end
            end
            S_CMP: begin
                if (pass) begin
                    r_count <= r_count + 1'b1;
                end
            end
            default: ;
        endcase
        if (adv && !last_pix) begin
            if (r_y == r_y1) begin
                r_x <= r_x + 1'b1;
                r_y <= r_y0;
            end else begin
                r_y <= r_y + 1'b1;
            end
        end
        if ((r_state == S_FINISH) && can_finish) begin
            if (r_item.kind == KIND_READ) begin
                r_out.pixels_written <= '0;
                r_out.culled         <= 1'b0;
                r_out.read_depth     <= rd_in_range ? $signed(ram_rdata[WORD_W-1:COLOR_W])
                                                    : FAR_DEPTH;
                r_out.read_color     <= rd_in_range ? ram_rdata[COLOR_W-1:0] : '0;
            end else begin
                r_out.pixels_written <= r_count;
                r_out.culled         <= r_culled;
                r_out.read_depth     <= '0;
                r_out.read_color     <= '0;
            end
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

endmodule

/* src/trd_checker.sv */
module trd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input trd_pkg::t_out_item  i_out_data
);
    import trd_pkg::*;

    // Reset starts the clearing pass, so no request is taken in the next cycle.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request channel ready straight after reset");

    // One item at a time: an accepted request closes the channel for the next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second request taken while one is in work");

    // A culled triangle writes no pixels.
    a_culled_no_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.culled) |-> (i_out_data.pixels_written == '0))
        else $error("culled result reports written pixels");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind triangle_raster_depth_test_unit trd_checker u_trd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import trd_pkg::*;

    localparam int STORE_W = 256;
    localparam int STORE_H = 256;
    localparam int STORE_N = STORE_W * STORE_H;

    logic i_clk;
    logic i_rst_n;

    trd_in_if  req_ch ();
    trd_out_if res_ch ();
    trd_cfg_if cfg_ch ();

    triangle_raster_depth_test_unit #(
        .MAX_WIDTH  (STORE_W),
        .MAX_HEIGHT (STORE_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the frame buffer and registers.
    logic signed [DEPTH_W-1:0] depth_mirror [STORE_N];
    logic [COLOR_W-1:0]        color_mirror [STORE_N];
    int unsigned               frame_w_reg;
    int unsigned               frame_h_reg;

    t_out_item pending_results [$];
    int        error_count;
    int        burst_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Twice the signed area of three points, in 1/256 pixel squared.
    function automatic longint edge_fn(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        return (qx - px) * (ry - py) - (rx - px) * (qy - py);
    endfunction

    // Q12.4 to whole pixels, ties away from zero, clamped to [0, lim].
    function automatic int to_pixel(int v, int lim);
        int r;
        r = (v >= 0) ? ((v + 8) >>> 4) : -((-v + 8) >>> 4);
        if (r < 0) r = 0;
        if (r > lim) r = lim;
        return r;
    endfunction

    function automatic int min_of(int a, int b, int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic int max_of(int a, int b, int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Works out the result of one transaction and updates the mirror.
    function automatic t_out_item raster_predict(t_in_item it);
        t_out_item r;
        int        ax, ay, bx, by, cx, cy, w, h, x0, x1, y0, y1, count;
        longint    area, wa, wb, wc, num, den, q;
        int        idx;
        r = '0;
        if (it.kind == KIND_READ) begin
            r.read_depth = depth_mirror[it.pixel_index];
            r.read_color = color_mirror[it.pixel_index];
            return r;
        end
        ax = it.ax; ay = it.ay; bx = it.bx; by = it.by_coord; cx = it.cx; cy = it.cy;
        w  = (frame_w_reg > STORE_W) ? STORE_W : frame_w_reg;
        h  = (frame_h_reg > STORE_H) ? STORE_H : frame_h_reg;
        x0 = to_pixel(min_of(ax, bx, cx), w);
        x1 = to_pixel(max_of(ax, bx, cx), w);
        y0 = to_pixel(min_of(ay, by, cy), h);
        y1 = to_pixel(max_of(ay, by, cy), h);
        area  = edge_fn(ax, ay, bx, by, cx, cy);
        count = 0;
        if (area < 512) begin
            r.culled = 1'b1;
            return r;
        end
        for (int x = x0; x <= x1; x++) begin
            for (int y = y0; y <= y1; y++) begin
                wa = edge_fn(x * 16, y * 16, bx, by, cx, cy);
                wb = edge_fn(ax, ay, x * 16, y * 16, cx, cy);
                wc = edge_fn(ax, ay, bx, by, x * 16, y * 16);
                if (wa < 0 || wb < 0 || wc < 0 || x >= w || y >= h) continue;
                num = 2 * (longint'(it.az) * wa + longint'(it.bz) * wb
                         + longint'(it.cz) * wc) + area;
                den = 2 * area;
                q = (num >= 0) ? num / den : -((-num + den - 1) / den);
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                idx = y * STORE_W + x;
                if (q > depth_mirror[idx]) continue;
                depth_mirror[idx] = q[DEPTH_W-1:0];
                color_mirror[idx] = it.fill_color;
                count++;
            end
        end
        r.pixels_written = count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        error_count++;
    endtask

    // Sends one transaction, in bursts with random gaps, and records its result.
    task automatic send_item(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(raster_predict(it));
    endtask

    // Waits until every expected result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[FRAME_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CFG_FRAME_WIDTH) frame_w_reg = value & 9'h1FF;
        else frame_h_reg = value & 9'h1FF;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_in_item make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                          int az, int bz, int cz, int color);
        t_in_item it;
        it = '0;
        it.kind = KIND_DRAW;
        it.ax = ax[15:0]; it.ay = ay[15:0]; it.az = az[15:0];
        it.bx = bx[15:0]; it.by_coord = by[15:0]; it.bz = bz[15:0];
        it.cx = cx[15:0]; it.cy = cy[15:0]; it.cz = cz[15:0];
        it.fill_color = color[COLOR_W-1:0];
        it.pixel_index = INDEX_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_read(int x, int y);
        t_in_item it;
        it = '0;
        it.kind = KIND_READ;
        it.ax = COORD_W'($urandom);
        it.fill_color = COLOR_W'($urandom);
        it.pixel_index = 16'(y * STORE_W + x);
        return it;
    endfunction

    // Every field random; used only on a tiny frame so the box stays short.
    function automatic t_in_item make_noise();
        t_in_item   it;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    // A small triangle near (ox, oy) pixels, mostly counter-clockwise.
    function automatic t_in_item make_small_tri(int ox, int oy, int span);
        int ax, ay, bx, by, cx, cy, t;
        ax = ox * 16 + $urandom_range(0, span) - span / 2;
        ay = oy * 16 + $urandom_range(0, span) - span / 2;
        bx = ox * 16 + $urandom_range(0, span) - span / 2;
        by = oy * 16 + $urandom_range(0, span) - span / 2;
        cx = ox * 16 + $urandom_range(0, span) - span / 2;
        cy = oy * 16 + $urandom_range(0, span) - span / 2;
        if (edge_fn(ax, ay, bx, by, cx, cy) < 0 && $urandom_range(0, 9) != 0) begin
            t = bx; bx = cx; cx = t;
            t = by; by = cy; cy = t;
        end
        return make_tri(ax, ay, bx, by, cx, cy, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Reads of two corners and of the highest index straight after the clearing pass.
    task automatic test_cleared_store();
        t_in_item it;
        send_item(make_read(0, 0));
        send_item(make_read(STORE_W - 1, STORE_H - 1));
        it = make_read(0, 0);
        it.pixel_index = 16'hFFFF;
        send_item(it);
        drain();
    endtask

    // Area threshold, winding, vertex extremes and frame clamping on a tiny frame.
    task automatic test_edges_and_extremes();
        set_frame(6, 4);
        send_item(make_tri(0, 0, 32, 0, 0, 16, 100, 200, 300, 24'h123456));
        send_item(make_tri(0, 0, 31, 0, 0, 16, 1, 1, 1, 24'h111111));
        send_item(make_tri(0, 0, 0, 16, 32, 0, 1, 1, 1, 24'h222222));
        send_item(make_tri(0, 0, 64, 64, 32, 32, 1, 1, 1, 24'h333333));
        send_item(make_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                           -32768, 32767, 0, 24'hFFFFFF));
        send_item(make_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                           32767, 32767, 32767, 24'h000000));
        send_item(make_tri(32767, 32767, -32768, 32767, 32767, -32768,
                           -32768, -32768, -32768, 24'hABCDEF));
        send_item(make_read(0, 0));
        send_item(make_read(5, 3));
        send_item(make_read(6, 0));
        drain();
    endtask

    // Frame sizes of zero, one and above the store.
    task automatic test_frame_sizes();
        set_frame(0, 0);
        send_item(make_tri(0, 0, 160, 0, 0, 160, -5, -5, -5, 24'hFF0000));
        drain();
        set_frame(1, 1);
        send_item(make_tri(0, 0, 160, 0, 0, 160, -6, -6, -6, 24'h00FF00));
        send_item(make_read(0, 0));
        drain();
        set_frame(511, 511);
        send_item(make_tri(4080, 4080, 4300, 4080, 4080, 4300, -7, -7, -7, 24'h0000FF));
        send_item(make_read(255, 255));
        drain();
    endtask

    // Depth compare: equal depth passes, farther fails, nearer wins.
    task automatic test_depth_order();
        set_frame(256, 256);
        send_item(make_tri(640, 640, 720, 640, 640, 720, 50, 50, 50, 24'hAAAAAA));
        send_item(make_tri(640, 640, 720, 640, 640, 720, 50, 50, 50, 24'hBBBBBB));
        send_item(make_tri(640, 640, 720, 640, 640, 720, 51, 60, 70, 24'hCCCCCC));
        send_item(make_tri(640, 640, 720, 640, 640, 720, -900, 40, 49, 24'hDDDDDD));
        send_item(make_read(40, 40));
        drain();
    endtask

    // Random traffic: mostly small triangles over a hot area, with reads of it.
    task automatic test_random_traffic(int unsigned w, int unsigned h, int n);
        int hot;
        set_frame(w, h);
        hot = (w < 48) ? w + 2 : 48;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1: send_item(make_read($urandom_range(0, hot), $urandom_range(0, hot)));
                2: begin
                    if (w <= 8 && h <= 8) send_item(make_noise());
                    else send_item(make_read($urandom_range(0, 255), $urandom_range(0, 255)));
                end
                3: send_item(make_small_tri($urandom_range(0, 260), $urandom_range(0, 260), 96));
                default: send_item(make_small_tri($urandom_range(0, hot),
                                                  $urandom_range(0, hot), 96));
            endcase
        end
        drain();
    endtask

    // Receiver stalls in modes picked at random: always ready, mostly ready or rarely ready.
    initial begin
        int unsigned stall_mode;
        int unsigned cyc;
        res_ch.ready <= 1'b0;
        stall_mode = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 256 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 2) != 0);
                default: res_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result at %0t", $time);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.data.pixels_written != want.pixels_written)
                    report_mismatch("pixels_written", res_ch.data.pixels_written,
                                    want.pixels_written);
                if (res_ch.data.culled != want.culled)
                    report_mismatch("culled", res_ch.data.culled, want.culled);
                if (res_ch.data.read_depth != want.read_depth)
                    report_mismatch("read_depth", res_ch.data.read_depth, want.read_depth);
                if (res_ch.data.read_color != want.read_color)
                    report_mismatch("read_color", res_ch.data.read_color, want.read_color);
            end
        end
    end

    // Main sequence.
    initial begin
        for (int i = 0; i < STORE_N; i++) begin
            depth_mirror[i] = FAR_DEPTH;
            color_mirror[i] = '0;
        end
        frame_w_reg  = 256;
        frame_h_reg  = 256;
        error_count  = 0;
        burst_left   = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_FRAME_WIDTH;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_store();
        test_edges_and_extremes();
        test_frame_sizes();
        test_depth_order();
        test_random_traffic(256, 256, 700);
        test_random_traffic(100, 60, 400);
        test_random_traffic(8, 5, 400);

        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #400_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
src/trd_pkg.sv
src/trd_if.sv
src/trd_ram.sv
src/trd_div.sv
src/triangle_raster_depth_test_unit.sv
src/trd_checker.sv
bench/testbench.sv
